>>> rtl/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg
// shared types and constants of the rpn stack calculator
// ----------------------------------------------------------------------------
package rsc_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int DATA_W      = 32;
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DEPTH_W     = 5;
	localparam int BITCNT_W    = $clog2(DATA_W + 1);

	typedef enum logic [3:0] {
		OP_PUSH  = 4'd0,
		OP_ADD   = 4'd1,
		OP_SUB   = 4'd2,
		OP_MUL   = 4'd3,
		OP_DIV   = 4'd4,
		OP_POP   = 4'd5,
		OP_PEEK  = 4'd6,
		OP_SWAP  = 4'd7,
		OP_CLEAR = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FEW  = 2'd1,
		ST_FULL = 2'd2,
		ST_DIVZ = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ALU_ADD = 2'd0,
		ALU_SUB = 2'd1,
		ALU_MUL = 2'd2,
		ALU_DIV = 2'd3
	} alu_op_t;

	typedef struct packed {
		logic [3:0]               operation;
		logic signed [DATA_W-1:0] value;
	} cmd_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] top_value;
		logic [1:0]               status;
		logic [DEPTH_W-1:0]       depth;
	} res_word_t;

	typedef struct packed {
		logic        start;
		alu_op_t     op;
	} alu_req_t;

endpackage

>>> rtl/rsc_ram.sv
// ----------------------------------------------------------------------------
// rsc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/rsc_alu.sv
// ----------------------------------------------------------------------------
// rsc_alu
// bit serial add and subtract, shift-add multiply, restoring divide
// ----------------------------------------------------------------------------
module rsc_alu import rsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  alu_req_t          req,
	input  logic [DATA_W-1:0] a,
	input  logic [DATA_W-1:0] b,
	output logic              done,
	output logic [DATA_W-1:0] result
);

	logic [DATA_W-1:0]   x_q, y_q, acc_q, rem_q;
	logic                c_q, neg_q, busy_q, fix_q;
	alu_op_t             op_q;
	logic [BITCNT_W-1:0] cnt_q;
	logic [DATA_W:0]     trial;
	logic [DATA_W:0]     diff;
	logic                sbit, cout;

	assign sbit  = x_q[0] ^ y_q[0] ^ c_q;
	assign cout  = (x_q[0] & y_q[0]) | (x_q[0] & c_q) | (y_q[0] & c_q);
	assign trial = {rem_q, x_q[DATA_W-1]};
	assign diff  = trial - {1'b0, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == BITCNT_W'(DATA_W - 1)) begin
				busy_q <= 1'b0;
				fix_q  <= 1'b1;
			end else if (fix_q) begin
				fix_q <= 1'b0;
				done  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			cnt_q <= '0;
			acc_q <= '0;
			rem_q <= '0;
			c_q   <= (req.op == ALU_SUB);
			neg_q <= a[DATA_W-1] ^ b[DATA_W-1];
			case (req.op)
				ALU_ADD: begin
					x_q <= b;
					y_q <= a;
				end
				ALU_SUB: begin
					x_q <= b;
					y_q <= ~a;
				end
				ALU_MUL: begin
					x_q <= b;
					y_q <= a;
				end
				ALU_DIV: begin
					x_q <= b[DATA_W-1] ? (~b + 1'b1) : b;
					y_q <= a[DATA_W-1] ? (~a + 1'b1) : a;
				end
				default: begin
					x_q <= b;
					y_q <= a;
				end
			endcase
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			case (op_q)
				ALU_ADD, ALU_SUB: begin
					x_q <= {sbit, x_q[DATA_W-1:1]};
					y_q <= {1'b0, y_q[DATA_W-1:1]};
					c_q <= cout;
				end
				ALU_MUL: begin
					if (y_q[0]) begin
						acc_q <= acc_q + x_q;
					end
					x_q <= {x_q[DATA_W-2:0], 1'b0};
					y_q <= {1'b0, y_q[DATA_W-1:1]};
				end
				default: begin
					if (!diff[DATA_W]) begin
						rem_q <= diff[DATA_W-1:0];
						acc_q <= {acc_q[DATA_W-2:0], 1'b1};
					end else begin
						rem_q <= trial[DATA_W-1:0];
						acc_q <= {acc_q[DATA_W-2:0], 1'b0};
					end
					x_q <= {x_q[DATA_W-2:0], 1'b0};
				end
			endcase
		end else if (fix_q) begin
			case (op_q)
				ALU_ADD, ALU_SUB: result <= x_q;
				ALU_MUL:          result <= acc_q;
				default:          result <= neg_q ? (~acc_q + 1'b1) : acc_q;
			endcase
		end
	end

endmodule

>>> rtl/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// reverse polish integer calculator over a bounded stack held in ram
// ----------------------------------------------------------------------------
// one word at a time: after a word is taken, the two top entries are read
// from ram and a decision follows. pop, peek, clear, unused codes and flagged
// words then give their result word directly, push after one ram write and
// swap after two writes. add, sub, mul and div wait for the bit serial alu,
// which handles one bit of the operands per cycle, and for its start, its
// finish and the write back. the controller returns to idle as the result
// word is put out and takes the next word from there. a finished result
// waits in the output register while the next word is taken; a second
// finished result waits until it is taken
module rpn_stack_calculator import rsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_word_t cmd,
	output logic      res_valid,
	input  logic      res_stall,
	output res_word_t res
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RDA  = 8'b0000_0010,
		S_RDB  = 8'b0000_0100,
		S_DEC  = 8'b0000_1000,
		S_EXEC = 8'b0001_0000,
		S_WR1  = 8'b0010_0000,
		S_WR2  = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [3:0]          op_q;
	logic [DATA_W-1:0]   val_q, a_q, top_q, wr_data_q;
	logic [ADDR_W-1:0]   wr_addr_q;
	status_t             status_q;
	logic                swap_q;
	logic [CNT_W-1:0]    cnt_m1, cnt_m2;
	logic [ADDR_W-1:0]   raddr, waddr;
	logic [DATA_W-1:0]   rdata, wdata, cur_top;
	logic                we;
	alu_req_t            alu_req;
	logic                alu_done;
	logic [DATA_W-1:0]   alu_res;

	assign cnt_m1  = cnt_q - 1'b1;
	assign cnt_m2  = cnt_q - 2'd2;
	assign cur_top = (cnt_q == '0) ? '0 : a_q;
	assign raddr   = (state_q == S_RDB) ? cnt_m2[ADDR_W-1:0] : cnt_m1[ADDR_W-1:0];
	assign we      = (state_q == S_WR1) || (state_q == S_WR2);
	assign waddr   = (state_q == S_WR2) ? cnt_m2[ADDR_W-1:0] : wr_addr_q;
	assign wdata   = (state_q == S_WR2) ? a_q : wr_data_q;
	assign cmd_stall = (state_q != S_IDLE);

	rsc_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		alu_req.start = 1'b0;
		alu_req.op    = ALU_ADD;
		if (state_q == S_DEC) begin
			case (op_t'(op_q))
				OP_ADD: alu_req.op = ALU_ADD;
				OP_SUB: alu_req.op = ALU_SUB;
				OP_MUL: alu_req.op = ALU_MUL;
				OP_DIV: alu_req.op = ALU_DIV;
				default: alu_req.op = ALU_ADD;
			endcase
			case (op_t'(op_q))
				OP_ADD, OP_SUB, OP_MUL: alu_req.start = (cnt_q >= CNT_W'(2));
				OP_DIV: alu_req.start = (cnt_q >= CNT_W'(2)) && (a_q != '0);
				default: alu_req.start = 1'b0;
			endcase
		end
	end

	rsc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (a_q),
		.b      (rdata),
		.done   (alu_done),
		.result (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!res_valid || !res_stall)) begin
				res_valid <= 1'b1;
			end else if (res_valid && !res_stall) begin
				res_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_RDA;
					end
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: state_q <= S_DEC;
				S_DEC: begin
					state_q <= S_DONE;
					case (op_t'(op_q))
						OP_PUSH: begin
							if (cnt_q != CNT_W'(STACK_DEPTH)) begin
								cnt_q   <= cnt_q + 1'b1;
								state_q <= S_WR1;
							end
						end
						OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
							if (alu_req.start) begin
								state_q <= S_EXEC;
							end
						end
						OP_POP: begin
							if (cnt_q != '0) begin
								cnt_q <= cnt_m1;
							end
						end
						OP_SWAP: begin
							if (cnt_q >= CNT_W'(2)) begin
								state_q <= S_WR1;
							end
						end
						OP_CLEAR: cnt_q <= '0;
						default: ;
					endcase
				end
				S_EXEC: begin
					if (alu_done) begin
						cnt_q   <= cnt_m1;
						state_q <= S_WR1;
					end
				end
				S_WR1: state_q <= swap_q ? S_WR2 : S_DONE;
				S_WR2: state_q <= S_DONE;
				S_DONE: begin
					if (!res_valid || !res_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q  <= cmd.operation;
				val_q <= cmd.value;
			end
			S_RDB: a_q <= rdata;
			S_DEC: begin
				swap_q   <= 1'b0;
				status_q <= ST_OK;
				top_q    <= cur_top;
				case (op_t'(op_q))
					OP_PUSH: begin
						if (cnt_q == CNT_W'(STACK_DEPTH)) begin
							status_q <= ST_FULL;
						end else begin
							wr_addr_q <= cnt_q[ADDR_W-1:0];
							wr_data_q <= val_q;
							top_q     <= val_q;
						end
					end
					OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
						if (cnt_q < CNT_W'(2)) begin
							status_q <= ST_FEW;
						end else if (op_t'(op_q) == OP_DIV && a_q == '0) begin
							status_q <= ST_DIVZ;
						end
						wr_addr_q <= cnt_m2[ADDR_W-1:0];
					end
					OP_POP, OP_PEEK: begin
						if (cnt_q == '0) begin
							status_q <= ST_FEW;
						end
					end
					OP_SWAP: begin
						if (cnt_q < CNT_W'(2)) begin
							status_q <= ST_FEW;
						end else begin
							swap_q    <= 1'b1;
							wr_addr_q <= cnt_m1[ADDR_W-1:0];
							wr_data_q <= rdata;
							top_q     <= rdata;
						end
					end
					OP_CLEAR: top_q <= '0;
					default: ;
				endcase
			end
			S_EXEC: begin
				if (alu_done) begin
					wr_data_q <= alu_res;
					top_q     <= alu_res;
				end
			end
			S_DONE: begin
				if (!res_valid || !res_stall) begin
					res.top_value <= top_q;
					res.status    <= status_q;
					res.depth     <= DEPTH_W'(cnt_q);
				end
			end
			default: ;
		endcase
	end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the rpn stack calculator: directed and random
// command words with random gaps go in, a local stack model predicts each
// result word; a monitor checks every accepted one field by field in order
// ----------------------------------------------------------------------------
module tb;
	import rsc_pkg::*;

	localparam int QUIET_LIMIT = 20000;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_word_t cmd;
	logic      res_valid;
	logic      res_stall;
	res_word_t res;

	rpn_stack_calculator dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	cmd_word_t pending_cmds[$];
	res_word_t expected_res[$];
	logic [DATA_W-1:0] model_stack[STACK_DEPTH];
	int model_count;
	int errors;
	int sent_words;
	int checked_words;
	int quiet_cycles;
	bit hold_req;
	bit hold_res;
	bit hold_done;
	int hold_cycles;
	bit cmd_accepted;
	int driver_gap;
	int stall_gap;
	int seen_status[4];

	function automatic logic [DATA_W-1:0] div_trunc(logic [DATA_W-1:0] b, logic [DATA_W-1:0] a);
		logic [DATA_W-1:0] mb;
		logic [DATA_W-1:0] ma;
		logic [DATA_W-1:0] q;
		mb = b[DATA_W-1] ? -b : b;
		ma = a[DATA_W-1] ? -a : a;
		q = mb / ma;
		return (b[DATA_W-1] != a[DATA_W-1]) ? -q : q;
	endfunction

	function automatic res_word_t calc_step(cmd_word_t c);
		res_word_t r;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] t;
		logic [DATA_W-1:0] popped;
		bit use_popped;
		status_t st;
		st = ST_OK;
		use_popped = 0;
		popped = '0;
		case (c.operation)
			OP_PUSH: begin
				if (model_count >= STACK_DEPTH) st = ST_FULL;
				else begin
					model_stack[model_count] = c.value;
					model_count++;
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				if (model_count < 2) st = ST_FEW;
				else begin
					a = model_stack[model_count-1];
					b = model_stack[model_count-2];
					if (c.operation == OP_DIV && a == '0) st = ST_DIVZ;
					else begin
						case (c.operation)
							OP_ADD: t = b + a;
							OP_SUB: t = b - a;
							OP_MUL: t = b * a;
							default: t = div_trunc(b, a);
						endcase
						model_stack[model_count-2] = t;
						model_count--;
					end
				end
			end
			OP_POP: begin
				if (model_count < 1) st = ST_FEW;
				else begin
					popped = model_stack[model_count-1];
					model_count--;
					use_popped = 1;
				end
			end
			OP_PEEK: if (model_count < 1) st = ST_FEW;
			OP_SWAP: begin
				if (model_count < 2) st = ST_FEW;
				else begin
					t = model_stack[model_count-1];
					model_stack[model_count-1] = model_stack[model_count-2];
					model_stack[model_count-2] = t;
				end
			end
			OP_CLEAR: model_count = 0;
			default: ;
		endcase
		r.top_value = use_popped ? popped : (model_count > 0 ? model_stack[model_count-1] : '0);
		r.status = st;
		r.depth = model_count[DEPTH_W-1:0];
		return r;
	endfunction

	task automatic report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
		$display("mismatch on word %0d: %s got %0h expected %0h", checked_words, what, got, want);
		errors++;
	endtask

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return '0;
			4: return $urandom_range(0, 9);
			5: return -$urandom_range(1, 9);
			default: return $urandom;
		endcase
	endfunction

	task automatic add_cmd(logic [3:0] op, logic [DATA_W-1:0] v);
		cmd_word_t c;
		c.operation = op;
		c.value = v;
		pending_cmds.push_back(c);
	endtask

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// command acceptance seen at the rising edge
	always @(posedge clk) begin
		cmd_accepted <= arst_n && cmd_valid && !cmd_stall;
	end

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 0;
			cmd <= '0;
			driver_gap <= 0;
		end else if (!cmd_valid || cmd_accepted) begin
			if (cmd_valid) sent_words++;
			if (driver_gap > 0) begin
				cmd_valid <= 0;
				driver_gap <= driver_gap - 1;
			end else if (pending_cmds.size() > 0) begin
				cmd <= pending_cmds[0];
				expected_res.push_back(calc_step(pending_cmds.pop_front()));
				cmd_valid <= 1;
				driver_gap <= pick_gap();
			end else cmd_valid <= 0;
		end
	end

	// receiver stall
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1;
			stall_gap <= 0;
		end else if (hold_res) begin
			res_stall <= 1;
		end else if (stall_gap > 0) begin
			res_stall <= 1;
			stall_gap <= stall_gap - 1;
		end else begin
			res_stall <= 0;
			stall_gap <= (checked_words > 300 && checked_words < 330) ? 0 : pick_gap();
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || hold_res || (res_valid && !res_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (res_valid && !res_stall) begin
				if (expected_res.size() == 0) begin
					$display("unexpected result word %0d", checked_words);
					errors++;
				end else begin
					res_word_t e;
					e = expected_res.pop_front();
					if (res.top_value !== e.top_value) report("top_value", res.top_value, e.top_value);
					if (res.status !== e.status) report("status", res.status, e.status);
					if (res.depth !== e.depth) report("depth", res.depth, e.depth);
					seen_status[e.status]++;
				end
				checked_words++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
				$display("rpn_stack_calculator test failed");
				$finish;
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_res <= 0;
			hold_done <= 0;
			hold_cycles <= 0;
		end else if (hold_req && !hold_done) begin
			hold_cycles <= hold_cycles + 1;
			hold_res <= (hold_cycles < 400);
			hold_done <= (hold_cycles >= 400);
		end
	end

	initial begin
		int n;
		int ops;
		hold_req = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty stack cases, full stack, wraps, divide specials
		add_cmd(OP_POP, 0); add_cmd(OP_PEEK, 0); add_cmd(OP_ADD, 0); add_cmd(OP_SWAP, 0);
		add_cmd(OP_CLEAR, 0);
		add_cmd(OP_PUSH, 32'h8000_0000); add_cmd(OP_PUSH, 32'hffff_ffff);
		add_cmd(OP_DIV, 0);
		add_cmd(OP_PUSH, 32'h7fff_ffff); add_cmd(OP_PUSH, 1); add_cmd(OP_ADD, 0);
		add_cmd(OP_PUSH, 0); add_cmd(OP_DIV, 0);
		add_cmd(OP_PUSH, 32'h7fff_ffff); add_cmd(OP_MUL, 0); add_cmd(OP_SWAP, 0);
		add_cmd(OP_SUB, 0); add_cmd(OP_PUSH, -7); add_cmd(OP_DIV, 0); add_cmd(OP_PEEK, 0);
		add_cmd(4'd9, 32'h1234_5678); add_cmd(4'd15, 0);
		for (int i = 0; i < 17; i++) add_cmd(OP_PUSH, i - 8);
		add_cmd(OP_CLEAR, 0);
		wait (pending_cmds.size() == 0 && expected_res.size() == 0);

		// long receiver hold-off while words keep coming
		@(negedge clk);
		hold_req = 1;
		for (int i = 0; i < 30; i++) add_cmd(4'($urandom_range(0, 8)), pick_value());
		wait (hold_done);
		wait (pending_cmds.size() == 0 && expected_res.size() == 0);

		// random: mostly pushes and arithmetic, some noise and unused codes
		n = 0;
		while (n < 500) begin
			ops = $urandom_range(0, 99);
			if (ops < 35) add_cmd(OP_PUSH, pick_value());
			else if (ops < 75) add_cmd(4'($urandom_range(OP_ADD, OP_DIV)), $urandom);
			else if (ops < 96) add_cmd(4'($urandom_range(OP_POP, OP_CLEAR)), $urandom);
			else add_cmd(4'($urandom_range(9, 15)), $urandom);
			n++;
			if (n % 150 == 0) begin
				add_cmd(OP_CLEAR, 0);
				for (int i = 0; i < 16; i++) add_cmd(OP_PUSH, pick_value());
				add_cmd(OP_PUSH, $urandom);
			end
			if (pending_cmds.size() > 40) wait (pending_cmds.size() < 10);
		end
		wait (pending_cmds.size() == 0 && expected_res.size() == 0);
		repeat (100) @(posedge clk);

		$display("sent %0d command words, checked %0d result words", sent_words, checked_words);
		$display("status seen: ok %0d, too few %0d, full %0d, divide by zero %0d",
			seen_status[0], seen_status[1], seen_status[2], seen_status[3]);
		if (errors == 0 && expected_res.size() == 0) begin
			$display("rpn_stack_calculator test passed");
		end else begin
			$display("rpn_stack_calculator test failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/rsc_pkg.sv
rtl/rsc_ram.sv
rtl/rsc_alu.sv
rtl/rpn_stack_calculator.sv
bench/tb.sv
